[hw/rtl/lpcs_pkg.sv]
// ----------------------------------------------------------------------------
// lpcs_pkg
// Shared types and constants of the landmark pose capture sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcs_pkg;

  // pose codes
  localparam logic [1:0] POSE_CENTER = 2'd0;
  localparam logic [1:0] POSE_LEFT   = 2'd1;
  localparam logic [1:0] POSE_RIGHT  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MIN_STABLE = 1'b0;
  localparam logic CFG_POSE_SEQ   = 1'b1;

  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 4;
  localparam int STABLE_W    = 8;
  localparam int SEQ_SLOTS   = 8;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;

  localparam logic [STABLE_W-1:0] MIN_STABLE_RST = 8'd3;
  localparam logic [STABLE_W-1:0] STABLE_MAX     = 8'd255;

  // command (restart) code of the input channel
  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic              load;
    logic              square;
    logic              sum;
    logic              root_step;
    logic              root_last;
    logic              average;
    logic              classify;
    logic              commit;
    logic [LANE_W-1:0] lane;
  } lpcs_cmd_t;

  typedef struct packed {
    logic       restart;
    logic       face;
    logic [1:0] pose;
  } lpcs_frame_t;

endpackage : lpcs_pkg

`default_nettype wire

[hw/rtl/lpcs_ctrl.sv]
// ----------------------------------------------------------------------------
// lpcs_ctrl
// Sequencer: walks a face frame through squaring, square root per landmark,
// averaging, classification and hand-over; restart/no-face skip to hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_ctrl
  import lpcs_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_command,
  input  wire logic      in_face_present,
  output      logic      in_stall,
  input  wire logic      out_free,
  output      lpcs_cmd_t cmd
);

  localparam int ROOT_W   = COORD_BITS + 1;
  localparam int SQ_STEPS = (ROOT_W + 1) / 2;
  localparam int STEP_W   = $clog2(SQ_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_AVERAGE,
    S_CLASSIFY,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                in_fire;
  logic                step_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign step_last = (step_r == STEP_W'(SQ_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          lane_nxt = '0;
          if (in_command == CMD_RESTART || !in_face_present) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SQUARE;
          end
        end
      end
      S_SQUARE: state_nxt = S_SUM;
      S_SUM: begin
        step_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        step_nxt = step_r + 1'b1;
        if (step_last) begin
          if (lane_r == LANE_W'(LANES - 1)) begin
            state_nxt = S_AVERAGE;
          end else begin
            lane_nxt  = lane_r + 1'b1;
            state_nxt = S_SQUARE;
          end
        end
      end
      S_AVERAGE:  state_nxt = S_CLASSIFY;
      S_CLASSIFY: state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.lane      = lane_r;
    cmd.load      = in_fire;
    cmd.square    = (state_r == S_SQUARE);
    cmd.sum       = (state_r == S_SUM);
    cmd.root_step = (state_r == S_ROOT);
    cmd.root_last = (state_r == S_ROOT) && step_last;
    cmd.average   = (state_r == S_AVERAGE);
    cmd.classify  = (state_r == S_CLASSIFY);
    cmd.commit    = (state_r == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lane_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule : lpcs_ctrl

`default_nettype wire

[hw/rtl/lpcs_dpath.sv]
// ----------------------------------------------------------------------------
// lpcs_dpath
// Geometry datapath: landmark latch, squared distance to the nose, shared
// two-bits-per-cycle square root, average and pose classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_dpath
  import lpcs_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire lpcs_cmd_t             cmd,
  input  wire logic                  in_command,
  input  wire logic                  in_face_present,
  input  wire logic [COORD_BITS-1:0] in_landmark0_x,
  input  wire logic [COORD_BITS-1:0] in_landmark0_y,
  input  wire logic [COORD_BITS-1:0] in_landmark1_x,
  input  wire logic [COORD_BITS-1:0] in_landmark1_y,
  input  wire logic [COORD_BITS-1:0] in_nose_x,
  input  wire logic [COORD_BITS-1:0] in_nose_y,
  input  wire logic [COORD_BITS-1:0] in_landmark3_x,
  input  wire logic [COORD_BITS-1:0] in_landmark3_y,
  input  wire logic [COORD_BITS-1:0] in_landmark4_x,
  input  wire logic [COORD_BITS-1:0] in_landmark4_y,
  output      lpcs_frame_t           frame
);

  localparam int CW       = COORD_BITS;
  localparam int ROOT_W   = CW + 1;
  localparam int SQ_STEPS = (ROOT_W + 1) / 2;
  localparam int QW       = 2 * SQ_STEPS;
  localparam int RADW     = 2 * QW;
  localparam int REMW     = QW + 2;
  localparam int SUM4_W   = ROOT_W + 2;
  localparam int LIM_W    = ROOT_W + 4;

  logic [CW-1:0]     lm_x_r [LANES];
  logic [CW-1:0]     lm_y_r [LANES];
  logic [CW-1:0]     nose_x_r, nose_y_r;
  logic              restart_r, face_r;

  logic [2*CW-1:0]   sqx_r, sqy_r;
  logic [RADW-1:0]   rad_r;
  logic [REMW-1:0]   rem_r;
  logic [QW-1:0]     q_r;
  logic [ROOT_W-1:0] dist_r [LANES];
  logic [ROOT_W-1:0] avg_r;
  logic [LIM_W-1:0]  lim_r;
  logic [1:0]        pose_r;

  logic [CW-1:0]     px, py, dx, dy;
  logic [REMW-1:0]   r1, t1, rem1, r2, t2, rem2;
  logic [QW-1:0]     q1, q2;
  logic [SUM4_W-1:0] sum4;
  logic [ROOT_W-1:0] avg_nxt;
  logic [LIM_W-1:0]  ten [LANES];
  logic              is_left, is_right;

  // squared-distance operands of the current landmark
  always_comb begin
    px = lm_x_r[cmd.lane];
    py = lm_y_r[cmd.lane];
    dx = (px > nose_x_r) ? (px - nose_x_r) : (nose_x_r - px);
    dy = (py > nose_y_r) ? (py - nose_y_r) : (nose_y_r - py);
  end

  // two digit-by-digit root steps per cycle
  always_comb begin
    r1 = {rem_r[REMW-3:0], rad_r[RADW-1 -: 2]};
    t1 = {q_r, 2'b01};
    if (r1 >= t1) begin
      rem1 = r1 - t1;
      q1   = {q_r[QW-2:0], 1'b1};
    end else begin
      rem1 = r1;
      q1   = {q_r[QW-2:0], 1'b0};
    end
    r2 = {rem1[REMW-3:0], rad_r[RADW-3 -: 2]};
    t2 = {q1, 2'b01};
    if (r2 >= t2) begin
      rem2 = r2 - t2;
      q2   = {q1[QW-2:0], 1'b1};
    end else begin
      rem2 = r2;
      q2   = {q1[QW-2:0], 1'b0};
    end
  end

  always_comb begin
    sum4 = SUM4_W'(dist_r[0]) + SUM4_W'(dist_r[1]) + SUM4_W'(dist_r[2])
         + SUM4_W'(dist_r[3]);
    avg_nxt = sum4[SUM4_W-1:2];
    for (int i = 0; i < LANES; i++) begin
      ten[i] = LIM_W'({dist_r[i], 3'b000}) + LIM_W'({dist_r[i], 1'b0});
    end
    // lanes 0..3 hold the distances of landmarks 0, 1, 3 and 4
    is_left  = (ten[0] < lim_r) && (ten[2] < lim_r);
    is_right = (ten[1] < lim_r) && (ten[3] < lim_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lm_x_r[0] <= in_landmark0_x;
      lm_y_r[0] <= in_landmark0_y;
      lm_x_r[1] <= in_landmark1_x;
      lm_y_r[1] <= in_landmark1_y;
      lm_x_r[2] <= in_landmark3_x;
      lm_y_r[2] <= in_landmark3_y;
      lm_x_r[3] <= in_landmark4_x;
      lm_y_r[3] <= in_landmark4_y;
      nose_x_r  <= in_nose_x;
      nose_y_r  <= in_nose_y;
      restart_r <= (in_command == CMD_RESTART);
      face_r    <= in_face_present;
    end
    if (cmd.square) begin
      sqx_r <= {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
      sqy_r <= {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
    end
    if (cmd.sum) begin
      rad_r <= RADW'(sqx_r) + RADW'(sqy_r);
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.root_step) begin
      rad_r <= {rad_r[RADW-5:0], 4'b0000};
      rem_r <= rem2;
      q_r   <= q2;
    end
    if (cmd.root_last) begin
      dist_r[cmd.lane] <= q2[ROOT_W-1:0];
    end
    if (cmd.average) begin
      avg_r <= avg_nxt;
      lim_r <= LIM_W'({avg_nxt, 3'b000}) + LIM_W'(avg_nxt);
    end
    if (cmd.classify) begin
      if (avg_r == '0) begin
        pose_r <= POSE_CENTER;
      end else if (is_left) begin
        pose_r <= POSE_LEFT;
      end else if (is_right) begin
        pose_r <= POSE_RIGHT;
      end else begin
        pose_r <= POSE_CENTER;
      end
    end
  end

  assign frame.restart = restart_r;
  assign frame.face    = face_r;
  assign frame.pose    = pose_r;

endmodule : lpcs_dpath

`default_nettype wire

[hw/rtl/lpcs_track.sv]
// ----------------------------------------------------------------------------
// lpcs_track
// Capture tracking: configuration registers, slot index, pose stability and
// the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_track
  import lpcs_pkg::*;
#(
  parameter int CAPTURE_SLOTS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  commit,
  input  wire lpcs_frame_t           frame,
  output      logic                  out_free,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [1:0]            out_pose,
  output      logic                  out_captured,
  output      logic [COUNT_W-1:0]    out_capture_count,
  output      logic                  out_finished
);

  localparam int SLOT_W = $clog2(CAPTURE_SLOTS + 1);
  localparam int WIDE_W = SLOT_W + COUNT_W;

  logic [STABLE_W-1:0]   min_stable_r;
  logic [CFG_DATA_W-1:0] pose_seq_r;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [1:0]            last_pose_r, last_pose_nxt;
  logic [STABLE_W-1:0]   stable_r, stable_nxt;

  logic                  out_valid_r;
  logic [1:0]            out_pose_r, pose_nxt;
  logic                  out_captured_r, captured_nxt;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_finished_r;

  logic [WIDE_W-1:0]     slot_wide, slot_nxt_wide;
  logic [1:0]            req_pose;
  logic                  open_slots;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // slots past the eighth have no sequence bits and read as centre
  always_comb begin
    slot_wide = {{COUNT_W{1'b0}}, slot_r};
    if (slot_wide < WIDE_W'(SEQ_SLOTS)) begin
      req_pose = pose_seq_r[{slot_wide[2:0], 1'b0} +: 2];
    end else begin
      req_pose = POSE_CENTER;
    end
    open_slots = (slot_r < SLOT_W'(CAPTURE_SLOTS));
  end

  always_comb begin
    slot_nxt      = slot_r;
    last_pose_nxt = last_pose_r;
    stable_nxt    = stable_r;
    pose_nxt      = POSE_CENTER;
    captured_nxt  = 1'b0;
    if (frame.restart) begin
      slot_nxt      = '0;
      last_pose_nxt = POSE_CENTER;
      stable_nxt    = '0;
    end else if (frame.face) begin
      pose_nxt = frame.pose;
      if (open_slots) begin
        if (frame.pose == last_pose_r) begin
          if (stable_r != STABLE_MAX) begin
            stable_nxt = stable_r + 1'b1;
          end
        end else begin
          last_pose_nxt = frame.pose;
          stable_nxt    = '0;
        end
        if (stable_nxt > min_stable_r && frame.pose == req_pose) begin
          slot_nxt     = slot_r + 1'b1;
          captured_nxt = 1'b1;
        end
      end
    end
    slot_nxt_wide = {{COUNT_W{1'b0}}, slot_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_stable_r <= MIN_STABLE_RST;
      pose_seq_r   <= '0;
      slot_r       <= '0;
      last_pose_r  <= POSE_CENTER;
      stable_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_STABLE: min_stable_r <= cfg_data[STABLE_W-1:0];
          CFG_POSE_SEQ:   pose_seq_r   <= cfg_data;
          default:        pose_seq_r   <= pose_seq_r;
        endcase
      end
      if (commit) begin
        slot_r      <= slot_nxt;
        last_pose_r <= last_pose_nxt;
        stable_r    <= stable_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_pose_r     <= pose_nxt;
      out_captured_r <= captured_nxt;
      out_count_r    <= slot_nxt_wide[COUNT_W-1:0];
      out_finished_r <= (slot_nxt >= SLOT_W'(CAPTURE_SLOTS));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pose          = out_pose_r;
  assign out_captured      = out_captured_r;
  assign out_capture_count = out_count_r;
  assign out_finished      = out_finished_r;

endmodule : lpcs_track

`default_nettype wire

[hw/rtl/landmark_pose_capture_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// landmark_pose_capture_sequencer_unit
// Head-pose classifier and capture sequencer, one item per video frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one frame item, five landmarks plus the
// command and face flags. Output channel (out_valid / out_stall): one result
// per item, held in an output register. Configuration (cfg_valid / cfg_ready,
// cfg_index, cfg_data): index 0 minimum stable frames, index 1 pose sequence;
// cfg_ready is always high and writes belong to idle periods.
// Flow: a frame with a face runs the four landmark distances through one
// shared square-root unit resolving two root bits per cycle. Each distance
// passes squaring, summing and root steps; averaging and classification
// follow the fourth, then the result step. Restart and no-face items go
// straight to the result step. in_stall is high while an item is in flight;
// a waiting result does not block the next input transfer, but the next
// result waits in its final step while out_stall holds the register.
// Reset (rst_n low, synchronous) clears the slot index, stability count and
// last pose, loads the configuration reset values and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_pose_capture_sequencer_unit
  import lpcs_pkg::*;
#(
  parameter int CAPTURE_SLOTS = 8,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  in_command,
  input  wire logic                  in_face_present,
  input  wire logic [COORD_BITS-1:0] in_landmark0_x,
  input  wire logic [COORD_BITS-1:0] in_landmark0_y,
  input  wire logic [COORD_BITS-1:0] in_landmark1_x,
  input  wire logic [COORD_BITS-1:0] in_landmark1_y,
  input  wire logic [COORD_BITS-1:0] in_nose_x,
  input  wire logic [COORD_BITS-1:0] in_nose_y,
  input  wire logic [COORD_BITS-1:0] in_landmark3_x,
  input  wire logic [COORD_BITS-1:0] in_landmark3_y,
  input  wire logic [COORD_BITS-1:0] in_landmark4_x,
  input  wire logic [COORD_BITS-1:0] in_landmark4_y,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [1:0]            out_pose,
  output      logic                  out_captured,
  output      logic [COUNT_W-1:0]    out_capture_count,
  output      logic                  out_finished
);

  lpcs_cmd_t   cmd;
  lpcs_frame_t frame;
  logic        out_free;

  lpcs_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_command     (in_command),
    .in_face_present(in_face_present),
    .in_stall       (in_stall),
    .out_free       (out_free),
    .cmd            (cmd)
  );

  lpcs_dpath #(
    .COORD_BITS(COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .in_command     (in_command),
    .in_face_present(in_face_present),
    .in_landmark0_x (in_landmark0_x),
    .in_landmark0_y (in_landmark0_y),
    .in_landmark1_x (in_landmark1_x),
    .in_landmark1_y (in_landmark1_y),
    .in_nose_x      (in_nose_x),
    .in_nose_y      (in_nose_y),
    .in_landmark3_x (in_landmark3_x),
    .in_landmark3_y (in_landmark3_y),
    .in_landmark4_x (in_landmark4_x),
    .in_landmark4_y (in_landmark4_y),
    .frame          (frame)
  );

  lpcs_track #(
    .CAPTURE_SLOTS(CAPTURE_SLOTS)
  ) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .commit           (cmd.commit),
    .frame            (frame),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pose         (out_pose),
    .out_captured     (out_captured),
    .out_capture_count(out_capture_count),
    .out_finished     (out_finished)
  );

endmodule : landmark_pose_capture_sequencer_unit

`default_nettype wire

[hw/rtl/lpcs_checker.sv]
// ----------------------------------------------------------------------------
// lpcs_checker
// Port-level checks of the pose capture sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_checker
  import lpcs_pkg::*;
#(
  parameter int CAPTURE_SLOTS = 8
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [1:0]            out_pose,
  input wire logic                  out_captured,
  input wire logic [COUNT_W-1:0]    out_capture_count,
  input wire logic                  out_finished
);

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // the block is busy straight after taking an item
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  // the classifier never yields the unused pose code
  a_pose_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pose == POSE_CENTER || out_pose == POSE_LEFT ||
                   out_pose == POSE_RIGHT))
    else $error("illegal pose code");

  // finished reports exactly the full slot count
  a_finished_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_capture_count == COUNT_W'(CAPTURE_SLOTS))
    else $error("finished with wrong slot count");

  // a capture always leaves at least one slot filled
  a_capture_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_captured |-> (out_capture_count != '0 || out_finished))
    else $error("capture with empty slot count");

endmodule : lpcs_checker

bind landmark_pose_capture_sequencer_unit lpcs_checker #(
  .CAPTURE_SLOTS(CAPTURE_SLOTS)
) u_lpcs_checker (.*);

`default_nettype wire

[dv/tb_landmark_pose_capture_sequencer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_landmark_pose_capture_sequencer_unit
// Self-checking bench for the head-pose classifier and capture sequencer.
// A short table of hand-built frames opens the run. Random phases follow, each
// under its own register setting: held pose runs aimed at the next required
// slot, with restarts, faceless frames and raw noise mixed in. One long run
// drives the stability count into saturation. Every transfer is checked field
// by field on the result channel against a behavioural copy of the sequencer
// or a hand-set table result. Channels idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_landmark_pose_capture_sequencer_unit;
  import lpcs_pkg::*;

  localparam int CAPTURE_SLOTS = 8;
  localparam int COORD_BITS    = 12;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int NOSE          = 2;
  localparam int LONG_HOLD     = 400;
  localparam int STUCK_LIMIT   = 2000;
  localparam int DRAIN_TAIL    = 50;
  localparam int ERR_PRINT_MAX = 40;
  // pose code that no frame is ever given
  localparam logic [1:0] POSE_NONE = 2'd3;

  typedef struct packed {
    logic                       cmd;
    logic                       face;
    logic [4:0][COORD_BITS-1:0] px;
    logic [4:0][COORD_BITS-1:0] py;
  } frame_t;

  typedef struct packed {
    logic [1:0]         pose;
    logic               captured;
    logic [COUNT_W-1:0] count;
    logic               finished;
  } result_t;

  typedef struct packed {
    frame_t  frame;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_command;
  logic                  in_face_present;
  logic [COORD_BITS-1:0] in_landmark0_x, in_landmark0_y;
  logic [COORD_BITS-1:0] in_landmark1_x, in_landmark1_y;
  logic [COORD_BITS-1:0] in_nose_x, in_nose_y;
  logic [COORD_BITS-1:0] in_landmark3_x, in_landmark3_y;
  logic [COORD_BITS-1:0] in_landmark4_x, in_landmark4_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_pose;
  logic                  out_captured;
  logic [COUNT_W-1:0]    out_capture_count;
  logic                  out_finished;

  // predictor state and register copies
  int               slot_idx;
  logic [1:0]       last_pose;
  logic [STABLE_W-1:0] stable_cnt;
  logic [STABLE_W-1:0] min_stable_sh;
  logic [15:0]      pose_seq_sh;

  result_t   expected_results[$];
  stim_row_t stim_table[$];
  int        fail_count   = 0;
  int        stuck_cycles = 0;
  bit        idle_on      = 1'b1;
  bit        hold_req     = 1'b0;

  landmark_pose_capture_sequencer_unit #(
    .CAPTURE_SLOTS(CAPTURE_SLOTS),
    .COORD_BITS   (COORD_BITS)
  ) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned nose_span(input frame_t f, input int k);
    int          dx, dy, b;
    int unsigned sq, root, trial;
    dx = int'(f.px[k]) - int'(f.px[NOSE]);
    dy = int'(f.py[k]) - int'(f.py[NOSE]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = dx * dx + dy * dy;
    root = 0;
    // floor root, one bit at a time from the top
    for (b = 12; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic logic [1:0] head_pose(input frame_t f);
    int unsigned s0, s1, s3, s4, mean, lim;
    s0 = nose_span(f, 0);
    s1 = nose_span(f, 1);
    s3 = nose_span(f, 3);
    s4 = nose_span(f, 4);
    mean = (s0 + s1 + s3 + s4) >> 2;
    lim = 9 * mean;
    if (mean == 0) return POSE_CENTER;
    if (10 * s0 < lim && 10 * s3 < lim) return POSE_LEFT;
    if (10 * s1 < lim && 10 * s4 < lim) return POSE_RIGHT;
    return POSE_CENTER;
  endfunction

  function automatic logic [1:0] slot_pose(input int s);
    if (s >= SEQ_SLOTS) return POSE_CENTER;
    return pose_seq_sh[2*s +: 2];
  endfunction

  function automatic result_t step_capture(input frame_t f);
    result_t    r;
    logic [1:0] p;
    r = '0;
    if (f.cmd == CMD_RESTART) begin
      slot_idx = 0;
      last_pose = POSE_CENTER;
      stable_cnt = '0;
    end else if (f.face) begin
      p = head_pose(f);
      r.pose = p;
      if (slot_idx < CAPTURE_SLOTS) begin
        if (p != last_pose) begin
          last_pose = p;
          stable_cnt = '0;
        end else if (stable_cnt != STABLE_MAX) begin
          stable_cnt++;
        end
        if (stable_cnt > min_stable_sh && p == slot_pose(slot_idx)) begin
          slot_idx++;
          r.captured = 1'b1;
        end
      end
    end
    r.count = slot_idx[COUNT_W-1:0];
    r.finished = (slot_idx >= CAPTURE_SLOTS);
    return r;
  endfunction

  // ---------------------------------------------------------------- frames

  function automatic frame_t mk_frame(input logic cmd, input logic face,
                                      input int x0, input int y0, input int x1, input int y1,
                                      input int xn, input int yn, input int x3, input int y3,
                                      input int x4, input int y4);
    frame_t f;
    f.cmd = cmd;
    f.face = face;
    f.px[0] = COORD_BITS'(x0); f.py[0] = COORD_BITS'(y0);
    f.px[1] = COORD_BITS'(x1); f.py[1] = COORD_BITS'(y1);
    f.px[NOSE] = COORD_BITS'(xn); f.py[NOSE] = COORD_BITS'(yn);
    f.px[3] = COORD_BITS'(x3); f.py[3] = COORD_BITS'(y3);
    f.px[4] = COORD_BITS'(x4); f.py[4] = COORD_BITS'(y4);
    return f;
  endfunction

  function automatic frame_t flat_frame(input logic cmd, input logic face, input int v);
    return mk_frame(cmd, face, v, v, v, v, v, v, v, v, v, v);
  endfunction

  function automatic frame_t random_frame(input logic cmd, input logic face);
    frame_t                f;
    bit                    flat;
    logic [COORD_BITS-1:0] v;
    int                    k;
    f.cmd = cmd;
    f.face = face;
    flat = ($urandom_range(0, 7) == 0);
    v = COORD_BITS'($urandom);
    for (k = 0; k < 5; k++) begin
      f.px[k] = flat ? v : COORD_BITS'($urandom);
      f.py[k] = flat ? v : COORD_BITS'($urandom);
    end
    return f;
  endfunction

  // Near points sit within n of the nose on each axis, far ones 6n..7n away,
  // which keeps the intended pose clear of the 0.9 threshold.
  function automatic frame_t shaped_frame(input logic [1:0] pose);
    frame_t f;
    int     n, k, mag;
    bit     near;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 290);
    f.cmd = CMD_FRAME;
    f.face = 1'b1;
    f.px[NOSE] = COORD_BITS'($urandom_range(7 * n, COORD_MAX - 7 * n));
    f.py[NOSE] = COORD_BITS'($urandom_range(7 * n, COORD_MAX - 7 * n));
    for (k = 0; k < 5; k++) begin
      if (k != NOSE) begin
        near = (pose == POSE_LEFT && (k == 0 || k == 3)) ||
               (pose == POSE_RIGHT && (k == 1 || k == 4));
        mag = near ? $urandom_range(0, n) : $urandom_range(6 * n, 7 * n);
        f.px[k] = COORD_BITS'($urandom_range(0, 1) ? int'(f.px[NOSE]) + mag
                                                   : int'(f.px[NOSE]) - mag);
        mag = near ? $urandom_range(0, n) : $urandom_range(6 * n, 7 * n);
        f.py[k] = COORD_BITS'($urandom_range(0, 1) ? int'(f.py[NOSE]) + mag
                                                   : int'(f.py[NOSE]) - mag);
      end
    end
    return f;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_payload(input frame_t f);
    in_command      <= f.cmd;
    in_face_present <= f.face;
    in_landmark0_x  <= f.px[0];
    in_landmark0_y  <= f.py[0];
    in_landmark1_x  <= f.px[1];
    in_landmark1_y  <= f.py[1];
    in_nose_x       <= f.px[NOSE];
    in_nose_y       <= f.py[NOSE];
    in_landmark3_x  <= f.px[3];
    in_landmark3_y  <= f.py[3];
    in_landmark4_x  <= f.px[4];
    in_landmark4_y  <= f.py[4];
  endtask

  // valid is left high after the transfer; a drain, or an idle gap in the next call, drops it
  task automatic offer_frame(input frame_t f, input logic typed, input result_t want);
    int      gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    put_payload(f);
    do @(posedge clk); while (in_stall !== 1'b0);
    r = step_capture(f);
    expected_results.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [STABLE_W-1:0] min_frames, input logic [15:0] seq);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN_STABLE;
    // upper bits are outside the register and must be dropped
    cfg_data  <= {8'($urandom), min_frames};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    min_stable_sh = min_frames;
    cfg_index <= CFG_POSE_SEQ;
    cfg_data  <= seq;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pose_seq_sh = seq;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_capture_phase(input int count);
    int         k, roll, run_left;
    logic [1:0] run_pose;
    run_left = 0;
    run_pose = POSE_CENTER;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4 || (slot_idx >= CAPTURE_SLOTS && roll < 30)) begin
        offer_frame(random_frame(CMD_RESTART, 1'($urandom)), 1'b0, '0);
      end else if (roll < 10) begin
        offer_frame(random_frame(CMD_FRAME, 1'b0), 1'b0, '0);
      end else if (roll < 16) begin
        offer_frame(random_frame(CMD_FRAME, 1'b1), 1'b0, '0);
      end else begin
        if (run_left == 0) begin
          run_pose = slot_pose(slot_idx);
          if (run_pose == POSE_NONE || $urandom_range(0, 3) == 0)
            run_pose = 2'($urandom_range(0, 2));
          run_left = $urandom_range(1, min_stable_sh + 3);
        end
        run_left--;
        offer_frame(shaped_frame(run_pose), 1'b0, '0);
      end
    end
  endtask

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= ERR_PRINT_MAX) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_error("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_pose !== want.pose)
          report_error($sformatf("pose %0d, expected %0d", out_pose, want.pose));
        if (out_captured !== want.captured)
          report_error($sformatf("captured %0b, expected %0b", out_captured, want.captured));
        if (out_capture_count !== want.count)
          report_error($sformatf("capture_count %0d, expected %0d",
                                 out_capture_count, want.count));
        if (out_finished !== want.finished)
          report_error($sformatf("finished %0b, expected %0b", out_finished, want.finished));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
    $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    frame_t  left_f, right_f, centre_f;
    result_t nil, quiet;
    int      k, faces, ph;

    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_STABLE;
    cfg_data = '0;
    put_payload('0);
    slot_idx = 0;
    last_pose = POSE_CENTER;
    stable_cnt = '0;
    min_stable_sh = MIN_STABLE_RST;
    pose_seq_sh = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    nil = '0;
    quiet = '{pose: POSE_CENTER, captured: 1'b0, count: '0, finished: 1'b0};
    left_f   = mk_frame(CMD_FRAME, 1'b1, 2010, 2000, 2300, 2400, 2000, 2000,
                        1990, 2000, 1700, 1600);
    right_f  = mk_frame(CMD_FRAME, 1'b1, 2300, 2400, 2010, 2000, 2000, 2000,
                        1700, 1600, 1990, 2000);
    centre_f = mk_frame(CMD_FRAME, 1'b1, 1600, 3000, 400, 3000, 1000, 3000,
                        1000, 3600, 1000, 2400);

    // reset setting: hold beyond three frames, every slot wants center
    stim_table.push_back('{flat_frame(CMD_FRAME, 1'b0, COORD_MAX), 1'b1, quiet});
    // zero average reads as center
    stim_table.push_back('{flat_frame(CMD_FRAME, 1'b1, 0), 1'b1, quiet});
    stim_table.push_back('{flat_frame(CMD_FRAME, 1'b1, COORD_MAX), 1'b1, quiet});
    stim_table.push_back('{mk_frame(CMD_FRAME, 1'b1, 0, 0, 0, 0, COORD_MAX, COORD_MAX,
                                    0, 0, 0, 0), 1'b1, quiet});
    // fourth center in a row passes the stability bar and takes slot 0
    stim_table.push_back('{mk_frame(CMD_FRAME, 1'b1, COORD_MAX, 0, 0, COORD_MAX, 0, 0,
                                    COORD_MAX, 0, 0, COORD_MAX), 1'b1,
                           '{pose: POSE_CENTER, captured: 1'b1, count: 4'd1, finished: 1'b0}});
    stim_table.push_back('{left_f, 1'b0, nil});
    stim_table.push_back('{left_f, 1'b0, nil});
    stim_table.push_back('{right_f, 1'b0, nil});
    stim_table.push_back('{flat_frame(CMD_RESTART, 1'b1, COORD_MAX), 1'b1, quiet});
    stim_table.push_back('{flat_frame(CMD_RESTART, 1'b0, 0), 1'b1, quiet});
    // a held center fills all eight slots
    for (k = 0; k < 11; k++) stim_table.push_back('{centre_f, 1'b0, nil});
    // once finished the pose is still reported, nothing else moves
    stim_table.push_back('{left_f, 1'b0, nil});
    stim_table.push_back('{flat_frame(CMD_FRAME, 1'b0, 7), 1'b0, nil});
    stim_table.push_back('{flat_frame(CMD_RESTART, 1'b1, 1234), 1'b1, quiet});
    foreach (stim_table[k]) offer_frame(stim_table[k].frame, stim_table[k].typed,
                                        stim_table[k].want);

    // every slot asks for the code no frame can have
    wait_drained();
    program_regs('0, 16'hFFFF);
    run_capture_phase(30);

    // long left run at the top stability bar: the count must saturate, not wrap
    wait_drained();
    program_regs(STABLE_MAX, 16'h5555);
    faces = 0;
    while (faces < 262) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_frame(random_frame(CMD_FRAME, 1'b0), 1'b0, nil);
      end else begin
        offer_frame(shaped_frame(POSE_LEFT), 1'b0, nil);
        faces++;
      end
    end
    wait_drained();
    program_regs(8'd250, 16'h5555);
    repeat (10) offer_frame(shaped_frame(POSE_LEFT), 1'b0, nil);

    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      program_regs((ph == 0) ? 8'd0 : 8'($urandom_range(1, 5)), 16'($urandom));
      idle_on = (ph != 1);
      // receiver holds off while frames keep coming, so the block backs up
      if (ph == 2) hold_req = 1'b1;
      run_capture_phase(25);
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
